// ===== hdl/fir_deconvolution_with_bypass_defines.svh =====
// Assertion macros for the FIR deconvolution block.
`ifndef FIR_DECONVOLUTION_WITH_BYPASS_DEFINES_SVH
`define FIR_DECONVOLUTION_WITH_BYPASS_DEFINES_SVH

`ifndef SYNTHESIS
`define FDB_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fir_deconvolution_with_bypass: same-cycle check failed");
`define FDB_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fir_deconvolution_with_bypass: next-cycle check failed");
`else
`define FDB_ASSERT_SAME(name, ante, cons)
`define FDB_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== hdl/firdec_pkg.sv =====
package firdec_pkg;

    localparam int TAPS           = 30;
    localparam int TAP_W          = $clog2(TAPS);
    localparam int COEF_FRAC_BITS = 20;
    localparam int COEF_TABLE_FRAC = 24;
    localparam int COEF_SHIFT     = COEF_TABLE_FRAC - COEF_FRAC_BITS;
    localparam int COEF_HALF      = (1 << COEF_SHIFT) >> 1;
    localparam int COEF_W         = COEF_FRAC_BITS;

    localparam int SMP_W   = 16;
    localparam int GAIN_W  = 12;
    localparam int OUT_W   = 24;
    localparam int B_W     = SMP_W + 1;
    localparam int ACC_W   = COEF_W + B_W + 5;
    localparam int LO_W    = ACC_W / 2;
    localparam int HI_W    = ACC_W - LO_W;
    localparam int MUL_A_W = HI_W + 1;
    localparam int P_W     = MUL_A_W + B_W;
    localparam int TP_W    = COEF_W + B_W;
    localparam int SC_W    = ACC_W + GAIN_W + 1;
    localparam int OUT_SH  = COEF_FRAC_BITS + 8;
    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET     = 12'd1741;
    localparam logic [SMP_W-1:0]  LOW_THR_RESET  = 16'd768;
    localparam logic [SMP_W-1:0]  HIGH_THR_RESET = 16'd1408;
    localparam logic [SMP_W-1:0]  WARMUP_RESET   = 16'd576;

    localparam int COEF_Q24 [TAPS] = '{
        3573328, -261841, -195190, -145505, -108468, -80858, -60276, -44933,
        -33495, -24969, -18613, -13875, -10343, -7710, -5747, -4284, -3193,
        -2380, -1773, -1321, -984, -732, -543, -402, -296, -215, -153, -105,
        -65, -31
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN     = 2'd0,
        CFG_LOW_THR  = 2'd1,
        CFG_HIGH_THR = 2'd2,
        CFG_WARMUP   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [SMP_W-1:0] sample;
        logic [SMP_W-1:0] sample_index;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic                    bypassed;
    } out_word_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [SMP_W-1:0]  low_threshold;
        logic [SMP_W-1:0]  high_threshold;
        logic [SMP_W-1:0]  warmup_limit;
    } cfg_t;

    typedef enum logic [1:0] {
        MUL_TAP = 2'd0,
        MUL_LO  = 2'd1,
        MUL_HI  = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic             load;
        logic             mul_en;
        mul_sel_t         mul_sel;
        logic [TAP_W-1:0] tap;
        logic             acc_en;
        logic             lo_cap;
        logic             sum_en;
        logic             out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // Coefficient k, rounded half up from the stored table precision.
    function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_W-1:0] k);
        int raw;
        int rounded;
        raw = 0;
        if (int'(k) < TAPS)
        begin
            raw = COEF_Q24[k];
        end
        rounded = (raw + COEF_HALF) >>> COEF_SHIFT;
        return rounded[COEF_W-1:0];
    endfunction

endpackage

// ===== hdl/fir_deconvolution_with_bypass.sv =====
// Thirty-tap FIR deconvolution of an unsigned Q8.8 sensor stream with raw bypass.
// Each accepted word shifts its sample into a zero-reset delay line, and one shared
// multiply-accumulate unit steps through the 30 taps, one tap per cycle; the sum is
// then scaled by the gain register in two partial products, rounded and saturated
// to signed Q16.8. Samples under the low threshold, or under the high threshold
// during warm-up, are returned unchanged with bypassed set. After acceptance, the
// controller steps through the tap states, a drain state, two scaling states and
// a sum state, and then loads the rounded result into the output register;
// a result still waiting in the output register holds that load back until it
// is taken. A new word is accepted in the cycle after the load, even while the
// previous result still waits in the output register. The user must write the
// registers only while idle; the block itself does not enforce this.
`include "fir_deconvolution_with_bypass_defines.svh"

module fir_deconvolution_with_bypass (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [firdec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [firdec_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  firdec_pkg::in_word_t                in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output firdec_pkg::out_word_t               out_data
);

    firdec_pkg::cfg_t          cfg;
    firdec_pkg::ctrl_cmd_t     cmd;
    firdec_pkg::dp_status_t    status;

    firdec_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    firdec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    firdec_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // A waiting result is never overwritten, an accepted word keeps the block busy,
    // and the accumulator is never cleared while it is summing.
    `FDB_ASSERT_SAME(a_out_load_free, cmd.out_load, status.out_free)
    `FDB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `FDB_ASSERT_NEXT(a_result_shown, cmd.out_load, out_valid)
    `FDB_ASSERT_SAME(a_no_load_while_acc, cmd.acc_en, !cmd.load)

endmodule

// ===== hdl/firdec_regs.sv =====
module firdec_regs (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [firdec_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [firdec_pkg::CFG_DATA_W-1:0]      cfg_data,
    output firdec_pkg::cfg_t                       cfg
);

    firdec_pkg::cfg_t cfg_reg;
    firdec_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (firdec_pkg::cfg_idx_t'(cfg_index))
                firdec_pkg::CFG_GAIN:
                    cfg_next.gain = cfg_data[firdec_pkg::GAIN_W-1:0];
                firdec_pkg::CFG_LOW_THR:
                    cfg_next.low_threshold = cfg_data[firdec_pkg::SMP_W-1:0];
                firdec_pkg::CFG_HIGH_THR:
                    cfg_next.high_threshold = cfg_data[firdec_pkg::SMP_W-1:0];
                firdec_pkg::CFG_WARMUP:
                    cfg_next.warmup_limit = cfg_data[firdec_pkg::SMP_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain           <= firdec_pkg::GAIN_RESET;
            cfg_reg.low_threshold  <= firdec_pkg::LOW_THR_RESET;
            cfg_reg.high_threshold <= firdec_pkg::HIGH_THR_RESET;
            cfg_reg.warmup_limit   <= firdec_pkg::WARMUP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/firdec_ctrl.sv =====
module firdec_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  firdec_pkg::dp_status_t   status,
    output firdec_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MAC   = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_SLO   = 7'b0001000,
        S_SHI   = 7'b0010000,
        S_SUM   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    localparam logic [firdec_pkg::TAP_W-1:0] LAST_TAP =
        firdec_pkg::TAP_W'(firdec_pkg::TAPS - 1);

    state_t                          state_reg;
    state_t                          state_next;
    logic [firdec_pkg::TAP_W-1:0]    tap_reg;
    logic [firdec_pkg::TAP_W-1:0]    tap_next;

    always_comb
    begin
        state_next  = state_reg;
        tap_next    = tap_reg;
        cmd         = '0;
        cmd.mul_sel = firdec_pkg::MUL_TAP;
        cmd.tap     = tap_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    tap_next   = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.mul_en = 1'b1;
                cmd.acc_en = (tap_reg != '0);
                if (tap_reg == LAST_TAP)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                cmd.acc_en = 1'b1;
                state_next = S_SLO;
            end
            S_SLO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = firdec_pkg::MUL_LO;
                state_next  = S_SHI;
            end
            S_SHI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = firdec_pkg::MUL_HI;
                cmd.lo_cap  = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== hdl/firdec_dp.sv =====
module firdec_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  firdec_pkg::cfg_t         cfg,
    input  firdec_pkg::in_word_t     in_data,
    input  firdec_pkg::ctrl_cmd_t    cmd,
    output firdec_pkg::dp_status_t   status,
    output logic                     out_valid,
    input  logic                     out_stall,
    output firdec_pkg::out_word_t    out_data
);

    localparam int SMP_W   = firdec_pkg::SMP_W;
    localparam int ACC_W   = firdec_pkg::ACC_W;
    localparam int LO_W    = firdec_pkg::LO_W;
    localparam int MUL_A_W = firdec_pkg::MUL_A_W;
    localparam int B_W     = firdec_pkg::B_W;
    localparam int P_W     = firdec_pkg::P_W;
    localparam int TP_W    = firdec_pkg::TP_W;
    localparam int SC_W    = firdec_pkg::SC_W;
    localparam int OUT_W   = firdec_pkg::OUT_W;

    localparam logic signed [SC_W-1:0] RND_HALF = SC_W'(1) << (firdec_pkg::OUT_SH - 1);
    localparam logic signed [SC_W-1:0] SAT_MAX  = SC_W'(firdec_pkg::OUT_MAX);
    localparam logic signed [SC_W-1:0] SAT_MIN  = SC_W'(firdec_pkg::OUT_MIN);

    logic [SMP_W-1:0]           dl_reg [firdec_pkg::TAPS];
    logic [SMP_W-1:0]           dl_next [firdec_pkg::TAPS];
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [P_W-1:0]      prod_reg;
    logic signed [P_W-1:0]      prod_next;
    logic signed [P_W-1:0]      lo_reg;
    logic signed [P_W-1:0]      lo_next;
    logic signed [SC_W-1:0]     scaled_reg;
    logic signed [SC_W-1:0]     scaled_next;
    logic [SMP_W-1:0]           sample_reg;
    logic [SMP_W-1:0]           sample_next;
    logic                       bypass_reg;
    logic                       bypass_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    firdec_pkg::out_word_t      out_data_reg;
    firdec_pkg::out_word_t      out_data_next;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [B_W-1:0]      mul_b;
    logic signed [SC_W-1:0]     rnd;
    logic signed [SC_W-1:0]     shifted;
    logic signed [SC_W-1:0]     sat;

    always_comb
    begin
        unique case (cmd.mul_sel)
            firdec_pkg::MUL_TAP:
            begin
                mul_a = MUL_A_W'(firdec_pkg::coef_at(cmd.tap));
                mul_b = $signed({1'b0, dl_reg[cmd.tap]});
            end
            firdec_pkg::MUL_LO:
            begin
                mul_a = $signed(MUL_A_W'(acc_reg[LO_W-1:0]));
                mul_b = $signed(B_W'(cfg.gain));
            end
            firdec_pkg::MUL_HI:
            begin
                mul_a = MUL_A_W'($signed(acc_reg[ACC_W-1:LO_W]));
                mul_b = $signed(B_W'(cfg.gain));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        dl_next     = dl_reg;
        sample_next = sample_reg;
        bypass_next = bypass_reg;
        acc_next    = acc_reg;
        if (cmd.load)
        begin
            for (int k = firdec_pkg::TAPS - 1; k > 0; k--)
            begin
                dl_next[k] = dl_reg[k-1];
            end
            dl_next[0]  = in_data.sample;
            sample_next = in_data.sample;
            bypass_next = (in_data.sample < cfg.low_threshold) ||
                          ((in_data.sample_index < cfg.warmup_limit) &&
                           (in_data.sample < cfg.high_threshold));
            acc_next    = '0;
        end
        else if (cmd.acc_en)
        begin
            acc_next = acc_reg + ACC_W'($signed(prod_reg[TP_W-1:0]));
        end
    end

    assign prod_next   = cmd.mul_en ? P_W'(mul_a * mul_b) : prod_reg;
    assign lo_next     = cmd.lo_cap ? prod_reg : lo_reg;
    assign scaled_next = cmd.sum_en ? (SC_W'(prod_reg) <<< LO_W) + SC_W'(lo_reg)
                                    : scaled_reg;

    assign rnd     = scaled_reg + RND_HALF;
    assign shifted = rnd >>> firdec_pkg::OUT_SH;

    always_comb
    begin
        priority if (shifted > SAT_MAX)
        begin
            sat = SAT_MAX;
        end
        else if (shifted < SAT_MIN)
        begin
            sat = SAT_MIN;
        end
        else
        begin
            sat = shifted;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.out_load)
        begin
            out_valid_next         = 1'b1;
            out_data_next.bypassed = bypass_reg;
            out_data_next.filtered = bypass_reg ? $signed(OUT_W'(sample_reg))
                                                : sat[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < firdec_pkg::TAPS; k++)
            begin
                dl_reg[k] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dl_reg        <= dl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        lo_reg       <= lo_next;
        scaled_reg   <= scaled_next;
        sample_reg   <= sample_next;
        bypass_reg   <= bypass_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== verif/fir_deconvolution_with_bypass_checker.sv =====
`timescale 1ns / 100ps

module fir_deconvolution_with_bypass_checker
    import firdec_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_word_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_word_t             out_data,
    output int                    errors,
    output int                    pending,
    output int                    results
);

    localparam int COEF_DROP = COEF_TABLE_FRAC - COEF_FRAC_BITS;
    localparam int SCALE_SH  = COEF_FRAC_BITS + 8;

    logic [SMP_W-1:0]  history [TAPS];
    logic [GAIN_W-1:0] gain_r;
    logic [SMP_W-1:0]  low_thr_r;
    logic [SMP_W-1:0]  high_thr_r;
    logic [SMP_W-1:0]  warmup_r;

    out_word_t filtered_q [$];
    int        mismatches;
    int        taken;

    // Shifts the sample into the history and returns the word the block should produce.
    function automatic out_word_t filter_word(input in_word_t w);
        out_word_t r;
        longint    sum;
        longint    coef;
        longint    scaled;
        logic      pass;
        int        k;
        for (k = TAPS - 1; k > 0; k--)
        begin
            history[k] = history[k-1];
        end
        history[0] = w.sample;
        sum = 0;
        for (k = 0; k < TAPS; k++)
        begin
            coef = (longint'(COEF_Q24[k]) + (longint'(1) << (COEF_DROP - 1))) >>> COEF_DROP;
            sum += coef * longint'(history[k]);
        end
        scaled = sum * longint'(gain_r);
        scaled = (scaled + (longint'(1) << (SCALE_SH - 1))) >>> SCALE_SH;
        if (scaled > OUT_MAX)
        begin
            scaled = OUT_MAX;
        end
        if (scaled < OUT_MIN)
        begin
            scaled = OUT_MIN;
        end
        pass = (w.sample < low_thr_r) || ((w.sample_index < warmup_r) && (w.sample < high_thr_r));
        r.bypassed = pass;
        r.filtered = pass ? {8'd0, w.sample} : scaled[OUT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp_w;
        if (!rst_n)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                history[k] = '0;
            end
            gain_r     = GAIN_RESET;
            low_thr_r  = LOW_THR_RESET;
            high_thr_r = HIGH_THR_RESET;
            warmup_r   = WARMUP_RESET;
            filtered_q.delete();
            mismatches = 0;
            taken      = 0;
            errors    <= 0;
            pending   <= 0;
            results   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GAIN:     gain_r     = cfg_data[GAIN_W-1:0];
                    CFG_LOW_THR:  low_thr_r  = cfg_data[SMP_W-1:0];
                    CFG_HIGH_THR: high_thr_r = cfg_data[SMP_W-1:0];
                    CFG_WARMUP:   warmup_r   = cfg_data[SMP_W-1:0];
                    default:      ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                taken++;
                if (filtered_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result word: filtered %0d bypassed %0b",
                                 out_data.filtered, out_data.bypassed);
                    end
                end
                else
                begin
                    exp_w = filtered_q.pop_front();
                    if (out_data.filtered !== exp_w.filtered || out_data.bypassed !== exp_w.bypassed)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result word %0d: filtered exp %0d got %0d, bypassed exp %0b got %0b",
                                     taken, exp_w.filtered, out_data.filtered,
                                     exp_w.bypassed, out_data.bypassed);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                filtered_q.push_back(filter_word(in_data));
            end
            errors  <= mismatches;
            pending <= filtered_q.size();
            results <= taken;
        end
    end

endmodule

// ===== verif/tb_fir_deconvolution_with_bypass.sv =====
`timescale 1ns / 100ps

module tb_fir_deconvolution_with_bypass;
    import firdec_pkg::*;

    localparam int WORDS_PER_PHASE = 150;
    localparam int RANDOM_PHASES   = 9;
    localparam int CYCLE_LIMIT     = 600000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_data;

    int errors;
    int pending;
    int results;
    int words_sent;
    int settings_used;
    int cycles;
    logic quiet;

    logic [GAIN_W-1:0] cur_gain;
    logic [SMP_W-1:0]  cur_low;
    logic [SMP_W-1:0]  cur_high;
    logic [SMP_W-1:0]  cur_warmup;
    int                level;
    logic [SMP_W-1:0]  stream_index;

    fir_deconvolution_with_bypass i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    fir_deconvolution_with_bypass_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending),
        .results   (results)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("fir_deconvolution_with_bypass regression: fail");
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 60)) @(posedge clk);
            end
        end
    end

    task automatic send_word(input logic [SMP_W-1:0] smp, input logic [SMP_W-1:0] idx);
        in_word_t w;
        w.sample       = smp;
        w.sample_index = idx;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_GAIN:     cur_gain   = data[GAIN_W-1:0];
            CFG_LOW_THR:  cur_low    = data;
            CFG_HIGH_THR: cur_high   = data;
            CFG_WARMUP:   cur_warmup = data;
            default:      ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] g, input logic [SMP_W-1:0] lo,
                             input logic [SMP_W-1:0] hi, input logic [SMP_W-1:0] wu);
        settle();
        write_reg(CFG_GAIN, g);
        write_reg(CFG_LOW_THR, lo);
        write_reg(CFG_HIGH_THR, hi);
        write_reg(CFG_WARMUP, wu);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int mode;
        int k;
        logic [SMP_W-1:0] thr;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_GAIN;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        quiet         = 1'b0;
        words_sent    = 0;
        settings_used = 1;
        cur_gain      = GAIN_RESET;
        cur_low       = LOW_THR_RESET;
        cur_high      = HIGH_THR_RESET;
        cur_warmup    = WARMUP_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Threshold and warm-up edges under the reset settings.
        send_word(16'd0, 16'd0);
        send_word(16'hFFFF, 16'hFFFF);
        send_word(16'd767, 16'd1000);
        send_word(16'd768, 16'd1000);
        send_word(16'd768, 16'd575);
        send_word(16'd1407, 16'd575);
        send_word(16'd1408, 16'd575);
        send_word(16'd1407, 16'd576);
        send_word(16'hFFFF, 16'd0);
        send_word(16'hAAAA, 16'h5555);
        send_word(16'h5555, 16'hAAAA);

        // Full gain with no bypass: a step up, then a drop to zero for negative output.
        configure(16'hFFFF, 16'd0, 16'd0, 16'd0);
        for (k = 0; k < 4; k++)
        begin
            send_word(16'hFFFF, 16'(k));
        end
        for (k = 0; k < 4; k++)
        begin
            send_word(16'd0, 16'(k + 4));
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: configure(16'h0FFF, 16'd0, 16'hFFFF, 16'hFFFF);
                1: configure(16'h0000, 16'hFFFF, 16'd0, 16'd0);
                2: configure({4'd0, GAIN_RESET}, LOW_THR_RESET, HIGH_THR_RESET, WARMUP_RESET);
                3: configure(16'h0001, 16'd0, 16'hFFFF, 16'd0);
                default:
                begin
                    if (p == RANDOM_PHASES - 1)
                    begin
                        quiet <= 1'b1;
                    end
                    configure(16'($urandom), 16'($urandom_range(0, 3000)),
                              16'($urandom_range(0, 6000)), 16'($urandom_range(0, 1000)));
                end
            endcase
            level = $urandom_range(0, 65535);
            stream_index = (p % 2 == 1) ? 16'(cur_warmup - 16'd75) : 16'd0;
            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                mode = $urandom_range(0, 9);
                case (mode)
                    6:
                    begin
                        thr = $urandom_range(0, 1) ? cur_low : cur_high;
                        send_word(16'(int'(thr) + int'($urandom_range(0, 4)) - 2),
                                  16'(int'(cur_warmup) + int'($urandom_range(0, 4)) - 2));
                    end
                    7:
                    begin
                        send_word(16'($urandom), 16'($urandom));
                    end
                    8:
                    begin
                        send_word($urandom_range(0, 1) ? 16'hFFFF : 16'h0000, stream_index);
                        stream_index++;
                    end
                    default:
                    begin
                        if (mode == 9)
                        begin
                            stream_index = 16'($urandom);
                        end
                        level = level + int'($urandom_range(0, 600)) - 300;
                        if (level < 0)
                        begin
                            level = 0;
                        end
                        if (level > 65535)
                        begin
                            level = 65535;
                        end
                        send_word(16'(level), stream_index);
                        stream_index++;
                    end
                endcase
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        $display("Sent %0d words under %0d register settings; %0d results were compared.",
                 words_sent, settings_used, results);
        $display("%s", {"Settings covered gain from 0 to 4095, thresholds at both ends ",
                        "and warm-up crossings."});
        if (errors == 0 && pending == 0)
        begin
            $display("fir_deconvolution_with_bypass regression: pass");
        end
        else
        begin
            $display("fir_deconvolution_with_bypass regression: fail");
        end
        $finish;
    end

endmodule
